// ===== sv/csc_pkg.sv =====
// Shared types, constants and helpers for the camera serial command framer.
// No dependencies; every other file of the block imports this package.
package csc_pkg;

    // Command codes on the cmd field
    typedef enum logic [1:0] {
        CMD_SET_MODE     = 2'd0,
        CMD_SET_GAIN     = 2'd1,
        CMD_SET_EXPOSURE = 2'd2,
        CMD_RESET_LINK   = 2'd3
    } cmd_t;

    // Register addresses on the camera side
    localparam logic [7:0] ADDR_MODE    = 8'h16;
    localparam logic [7:0] ADDR_GAIN    = 8'h20;
    localparam logic [7:0] ADDR_RESET   = 8'h18;
    localparam logic [7:0] ADDR_EXPO_HI = 8'h06;
    localparam logic [7:0] ADDR_EXPO_LO = 8'h05;

    localparam logic [15:0] RESET_VALUE = 16'h0020;
    localparam logic [15:0] GAIN_MAX_VALUE = 16'h003E;

    // Frame bytes
    localparam logic [7:0] FRAME_OPEN  = 8'h7E;  // '~'
    localparam logic [7:0] FRAME_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] LEAD_1      = 8'h30;  // '0'
    localparam logic [7:0] LEAD_2      = 8'h45;  // 'E'
    localparam logic [7:0] LEAD_3      = 8'h36;  // '6'
    localparam logic [7:0] LEAD_4      = 8'h30;  // '0'
    localparam logic [7:0] LEAD_5      = 8'h31;  // '1'
    localparam logic [7:0] LEAD_6      = 8'h32;  // '2'
    localparam logic [7:0] CSUM_BASE   = 8'h72;  // 0x60 + 0x12

    localparam logic [7:0] HEX_DIGIT_BASE  = 8'h30;
    localparam logic [7:0] HEX_LETTER_BASE = 8'h37;

    // Exposure: t = floor(max(ms,34) * 4 / 129)
    localparam logic [23:0] EXPO_MIN_MS = 24'd34;
    localparam int          EXPO_X_W    = 26;
    localparam int          EXPO_Q_W    = 19;
    localparam logic [24:0] DIV129_RECIP = 25'd33294320;  // floor(2^32 / 129)
    localparam logic [8:0]  DIVISOR      = 9'd129;

    // One queued command: up to two frames
    typedef struct packed {
        logic        two_frames;
        logic [7:0]  addr;
        logic [15:0] value0;
        logic [15:0] value1;
    } entry_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] n;
        n = {4'b0000, nib};
        hex_digit = (nib > 4'd9) ? (n + HEX_LETTER_BASE) : (n + HEX_DIGIT_BASE);
    endfunction

endpackage

// ===== sv/csc_front.sv =====
// Front end: accepts commands, maps values, divides exposure by 129/4.
// Depends on csc_pkg.
module csc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      cmd,
    input  logic [23:0]     arg,
    output logic            push_valid,
    input  logic            push_ready,
    output csc_pkg::entry_t push_entry
);
    import csc_pkg::*;

    // stage 1: mapping and reciprocal multiply
    logic                s1_valid_reg;
    logic                s1_expo_reg;
    logic [7:0]          s1_addr_reg;
    logic [15:0]         s1_value_reg;
    logic [EXPO_X_W-1:0] s1_x_reg;
    logic [EXPO_Q_W-1:0] s1_q0_reg;

    // stage 2: corrected entry
    logic                s2_valid_reg;
    entry_t              s2_entry_reg;

    logic                s1_ready;
    logic                s2_ready;
    logic                in_fire;
    logic [23:0]         ms;
    logic [EXPO_X_W-1:0] x;
    logic [50:0]         prod;
    logic [7:0]          addr_c;
    logic [15:0]         value_c;
    logic [26:0]         q0_times_d;
    logic [26:0]         rem;
    logic [EXPO_Q_W-1:0] q;

    assign s2_ready = !s2_valid_reg || push_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign in_fire  = in_valid && s1_ready;

    assign ms   = (arg < EXPO_MIN_MS) ? EXPO_MIN_MS : arg;
    assign x    = {ms, 2'b00};
    assign prod = 51'(x) * 51'(DIV129_RECIP);

    always_comb
    begin
        case (cmd_t'(cmd))
            CMD_SET_MODE:
            begin
                addr_c = ADDR_MODE;
                if (arg == 24'd1)
                    value_c = 16'h0002;
                else if (arg == 24'd2)
                    value_c = 16'h0000;
                else
                    value_c = 16'h0001;
            end
            CMD_SET_GAIN:
            begin
                addr_c = ADDR_GAIN;
                if (arg <= 24'd15)
                    value_c = {10'd0, arg[3:0], 2'b00};
                else if (arg == 24'd16)
                    value_c = GAIN_MAX_VALUE;
                else
                    value_c = 16'h0000;
            end
            CMD_SET_EXPOSURE:
            begin
                addr_c  = ADDR_EXPO_HI;
                value_c = 16'h0000;
            end
            default:
            begin
                addr_c  = ADDR_RESET;
                value_c = RESET_VALUE;
            end
        endcase
    end

    // quotient estimate is low by at most one
    assign q0_times_d = {s1_q0_reg, 7'd0} + 27'(s1_q0_reg);
    assign rem        = 27'(s1_x_reg) - q0_times_d;
    assign q          = (rem >= 27'(DIVISOR)) ? (s1_q0_reg + 1'b1) : s1_q0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_expo_reg  <= (cmd_t'(cmd) == CMD_SET_EXPOSURE);
            s1_addr_reg  <= addr_c;
            s1_value_reg <= value_c;
            s1_x_reg     <= x;
            s1_q0_reg    <= prod[50:32];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_entry_reg.two_frames <= s1_expo_reg;
            s2_entry_reg.addr       <= s1_addr_reg;
            s2_entry_reg.value0     <= s1_expo_reg ? {13'd0, q[18:16]} : s1_value_reg;
            s2_entry_reg.value1     <= q[15:0];
        end
    end

    assign push_valid = s2_valid_reg;
    assign push_entry = s2_entry_reg;

endmodule

// ===== sv/csc_queue.sv =====
// Short register queue of command entries between front and back end.
// Depends on csc_pkg.
module csc_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  csc_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop,
    output csc_pkg::entry_t pop_entry
);
    import csc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t            mem [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_entry  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/csc_back.sv =====
// Back end: serializes one queued command into 16-byte ASCII frames.
// Depends on csc_pkg.
module csc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop,
    input  csc_pkg::entry_t pop_entry,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      frame_byte,
    output logic            frame_end,
    output logic            command_end
);
    import csc_pkg::*;

    logic        busy_reg;
    entry_t      entry_reg;
    logic [3:0]  cnt_reg;
    logic        sel_reg;

    logic        out_valid_reg;
    logic [7:0]  byte_reg;
    logic        frame_end_reg;
    logic        command_end_reg;

    logic        load_out;
    logic        last_in_frame;
    logic        last_byte;
    logic        cmd_done;
    logic [7:0]  addr;
    logic [15:0] value;
    logic [7:0]  csum;
    logic [7:0]  byte_c;

    assign addr  = sel_reg ? ADDR_EXPO_LO : entry_reg.addr;
    assign value = sel_reg ? entry_reg.value1 : entry_reg.value0;
    assign csum  = CSUM_BASE + addr + value[15:8] + value[7:0];

    always_comb
    begin
        case (cnt_reg)
            4'd0:    byte_c = FRAME_OPEN;
            4'd1:    byte_c = LEAD_1;
            4'd2:    byte_c = LEAD_2;
            4'd3:    byte_c = LEAD_3;
            4'd4:    byte_c = LEAD_4;
            4'd5:    byte_c = LEAD_5;
            4'd6:    byte_c = LEAD_6;
            4'd7:    byte_c = hex_digit(addr[7:4]);
            4'd8:    byte_c = hex_digit(addr[3:0]);
            4'd9:    byte_c = hex_digit(value[15:12]);
            4'd10:   byte_c = hex_digit(value[11:8]);
            4'd11:   byte_c = hex_digit(value[7:4]);
            4'd12:   byte_c = hex_digit(value[3:0]);
            4'd13:   byte_c = hex_digit(csum[7:4]);
            4'd14:   byte_c = hex_digit(csum[3:0]);
            default: byte_c = FRAME_CLOSE;
        endcase
    end

    assign last_in_frame = (cnt_reg == 4'd15);
    assign last_byte     = last_in_frame && (sel_reg || !entry_reg.two_frames);
    assign load_out      = busy_reg && (!out_valid_reg || !out_stall);
    assign cmd_done      = load_out && last_byte;
    assign pop           = pop_valid && (!busy_reg || cmd_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                sel_reg  <= 1'b0;
            end
            else
            begin
                if (cmd_done)
                    busy_reg <= 1'b0;
                if (load_out)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (last_in_frame)
                        sel_reg <= 1'b1;
                end
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            entry_reg <= pop_entry;
        if (load_out)
        begin
            byte_reg        <= byte_c;
            frame_end_reg   <= last_in_frame;
            command_end_reg <= last_byte;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = byte_reg;
    assign frame_end   = frame_end_reg;
    assign command_end = command_end_reg;

endmodule

// ===== sv/camera_serial_command_framer.sv =====
// Camera serial command framer, top level.
// Instantiates csc_front, csc_queue and csc_back; depends on csc_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall, cmd, arg): one camera command per
//   transfer. cmd 0 set mode, 1 set gain, 2 set exposure, 3 reset link.
//   Output channel (out_valid / out_stall, frame_byte, frame_end,
//   command_end): one ASCII frame byte per transfer. Each frame is 16 bytes,
//   '~' "0E6012" then hex addr, value hi, value lo, checksum, then '>'.
//   frame_end marks '>' of every frame; command_end marks the last byte of
//   a command. Set exposure gives two frames (32 transfers), the rest one
//   frame (16 transfers).
// Path: a command passes the two front stages, the queue, the back-end
//   entry register and the output register before its first byte appears.
// Throughput: one output byte per cycle while out_stall is low, set by
//   the byte serializer in the back end. The front end takes a command
//   every cycle until the QUEUE_DEPTH-entry queue fills.
// Stall: out_stall holds the output register; the back end freezes, the
//   queue fills, and then in_stall rises.
// Reset: rst_n asynchronous, active low; empties the pipeline and queue.
module camera_serial_command_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [23:0] arg,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_end,
    output logic        command_end
);
    import csc_pkg::*;

    // front -> queue
    logic   push_valid;
    logic   push_ready;
    entry_t push_entry;

    // queue -> back
    logic   pop_valid;
    logic   pop;
    entry_t pop_entry;

    // Front: value mapping and exact exposure divide
    csc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .arg        (arg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decoupling queue of command entries
    csc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    // Back: byte serializer with output register
    csc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop         (pop),
        .pop_entry   (pop_entry),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .command_end (command_end)
    );

endmodule

// ===== sv/csc_checker.sv =====
// Port-level checks for the camera serial command framer, plus its bind.
// Depends on csc_pkg.
module csc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_byte,
    input logic       frame_end,
    input logic       command_end
);
    import csc_pkg::*;

    // stalled output transfer stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte)
            && $stable(frame_end) && $stable(command_end))
        else $error("output changed while stalled");

    // frame end byte is always the closing character
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> frame_byte == FRAME_CLOSE)
        else $error("frame_end on a byte other than the closing one");

    // a command only ends at a frame end
    a_cmd_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command_end |-> frame_end)
        else $error("command_end without frame_end");

    // after a frame end transfer, the next byte starts a new frame
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_end ##1 out_valid |-> frame_byte == FRAME_OPEN)
        else $error("frame does not open after a frame end");

endmodule

bind camera_serial_command_framer csc_checker u_csc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end),
    .command_end (command_end)
);

// ===== dv/camera_frame_checker.sv =====
// Frame checker for the camera serial command framer: predicts every frame byte
// from accepted commands and compares it with the output stream.
// Depends on csc_pkg for the command codes, register addresses and frame bytes.
module camera_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [23:0] arg,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    input  logic        command_end,
    output int          fail_count,
    output int          pending
);
    import csc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       fend;
        logic       cend;
    } frame_beat_t;

    frame_beat_t expected_beats[$];

    function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        // '0'..'9' then 'A'..'F'
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h41 + wide - 8'd10);
    endfunction

    task automatic queue_frame(input logic [7:0] addr, input logic [15:0] value,
                               input logic last);
        logic [7:0]  text [16];
        logic [7:0]  sum;
        frame_beat_t beat;
        sum = CSUM_BASE + addr + value[15:8] + value[7:0];
        text[0]  = FRAME_OPEN;
        text[1]  = LEAD_1;
        text[2]  = LEAD_2;
        text[3]  = LEAD_3;
        text[4]  = LEAD_4;
        text[5]  = LEAD_5;
        text[6]  = LEAD_6;
        text[7]  = ascii_hex(addr[7:4]);
        text[8]  = ascii_hex(addr[3:0]);
        text[9]  = ascii_hex(value[15:12]);
        text[10] = ascii_hex(value[11:8]);
        text[11] = ascii_hex(value[7:4]);
        text[12] = ascii_hex(value[3:0]);
        text[13] = ascii_hex(sum[7:4]);
        text[14] = ascii_hex(sum[3:0]);
        text[15] = FRAME_CLOSE;
        for (int k = 0; k < 16; k++)
        begin
            beat.data = text[k];
            beat.fend = (k == 15);
            beat.cend = (k == 15) && last;
            expected_beats.push_back(beat);
        end
    endtask

    task automatic predict_command(input cmd_t op, input logic [23:0] a);
        logic [15:0] value;
        int unsigned ms;
        int unsigned ticks;
        case (op)
            CMD_SET_MODE:
            begin
                if (a == 24'd1)
                    value = 16'h0002;
                else if (a == 24'd2)
                    value = 16'h0000;
                else
                    value = 16'h0001;   // out-of-range index falls back to mode 0
                queue_frame(ADDR_MODE, value, 1'b1);
            end
            CMD_SET_GAIN:
            begin
                if (a <= 24'd15)
                    value = {a[13:0], 2'b00};
                else if (a == 24'd16)
                    value = 16'h003E;
                else
                    value = 16'h0000;
                queue_frame(ADDR_GAIN, value, 1'b1);
            end
            CMD_SET_EXPOSURE:
            begin
                ms = (a < EXPO_MIN_MS) ? int'(EXPO_MIN_MS) : int'(a);
                ticks = (ms * 4) / 129;
                queue_frame(ADDR_EXPO_HI, ticks[31:16], 1'b0);
                queue_frame(ADDR_EXPO_LO, ticks[15:0], 1'b1);
            end
            default:
                queue_frame(ADDR_RESET, 16'h0020, 1'b1);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_beat_t want;
        frame_beat_t got;
        if (!rst_n)
        begin
            expected_beats.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_command(cmd_t'(cmd), arg);
            if (out_valid && !out_stall)
            begin
                got = '{frame_byte, frame_end, command_end};
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected frame byte %h end %b cmd_end %b",
                             $time, got.data, got.fend, got.cend);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected byte %h end %b cmd_end %b, got %h %b %b",
                                 $time, want.data, want.fend, want.cend,
                                 got.data, got.fend, got.cend);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_beats.size();
        end
    end

endmodule

// ===== dv/camera_serial_command_framer_test.sv =====
// Testbench top for the camera serial command framer: drives camera commands,
// paces the frame byte receiver and gives the verdict.
// Depends on csc_pkg, camera_serial_command_framer and camera_frame_checker.
module camera_serial_command_framer_test;
    import csc_pkg::*;

    localparam int RANDOM_ITEMS = 240;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the queue
    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 40;    // settle time after the last byte

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [23:0] arg;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic        command_end;

    int fail_count;
    int pending;       // frame bytes predicted but not yet seen
    int quiet_cycles;

    // Shared pacing controls between the command sender and the byte receiver
    bit steady_flow;   // both sides transfer back to back while set
    bit hold_request;  // receiver does one long hold-off when it sees this

    camera_serial_command_framer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .arg         (arg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .command_end (command_end)
    );

    camera_frame_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .arg         (arg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end),
        .command_end (command_end),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a run that stops moving in both directions is a hang.
    // The longest legal quiet stretch is the receiver hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Byte receiver. Stalls at random before each transfer, none while
    // steady_flow is set, and one long hold-off on request so the framer's
    // queue fills and in_stall has to rise.
    initial
    begin : receiver
        int wait_cycles;
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                wait_cycles = steady_flow ? 0 : $urandom_range(0, 3);
                if (wait_cycles > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_cycles) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // One command transfer. A random idle gap may come first; with no
    // gap, in_valid simply stays high into the next transfer.
    task automatic send_command(input cmd_t op, input logic [23:0] value);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        arg      <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering commands until every predicted byte has been transferred.
    task automatic drain_frames();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        cmd_t        op;
        logic [23:0] value;
        rst_n    = 1'b0;
        in_valid <= 1'b0;
        cmd      <= CMD_SET_MODE;
        arg      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each mode index incl. the fallback, gain table edges,
        // exposure clamp at 34 ms and the first nonzero high frame, reset
        // with arg at both extremes.
        send_command(CMD_SET_MODE, 24'd0);
        send_command(CMD_SET_MODE, 24'd1);
        send_command(CMD_SET_MODE, 24'd2);
        send_command(CMD_SET_MODE, 24'd3);
        send_command(CMD_SET_MODE, 24'hFFFFFF);
        send_command(CMD_SET_GAIN, 24'd0);
        send_command(CMD_SET_GAIN, 24'd15);
        send_command(CMD_SET_GAIN, 24'd16);
        send_command(CMD_SET_GAIN, 24'd17);
        send_command(CMD_SET_GAIN, 24'hFFFFFF);
        send_command(CMD_SET_EXPOSURE, 24'd0);
        send_command(CMD_SET_EXPOSURE, 24'd33);
        send_command(CMD_SET_EXPOSURE, 24'd34);
        send_command(CMD_SET_EXPOSURE, 24'd35);
        send_command(CMD_SET_EXPOSURE, 24'd129);
        send_command(CMD_SET_EXPOSURE, 24'd2113535);   // t just below 2^16
        send_command(CMD_SET_EXPOSURE, 24'd2113536);   // t reaches 2^16
        send_command(CMD_SET_EXPOSURE, 24'hFFFFFF);
        send_command(CMD_RESET_LINK, 24'd0);
        send_command(CMD_RESET_LINK, 24'hFFFFFF);
        drain_frames();

        // Random commands; arg weighted toward the mapping edges, with full
        // 24-bit values so every bit toggles.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 90)
                steady_flow = 1'b1;
            if (i == 130)
                steady_flow = 1'b0;
            if (i == 170)
                hold_request = 1'b1;    // sender keeps offering meanwhile
            if (i == 210)
                drain_frames();
            op = cmd_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: value = 24'($urandom_range(0, 20));
                1: value = 24'($urandom_range(0, 200));
                2: value = 24'($urandom_range(2113400, 2113700));
                default: value = 24'($urandom());
            endcase
            send_command(op, value);
        end

        drain_frames();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
